// ===== rtl/i2a_fmt_pkg.sv =====
// Shared types, constants and helpers for the integer to ASCII formatter.
// Used by the controller, the datapath and the top level; depends on nothing.
package i2a_fmt_pkg;

	localparam int VALUE_BITS_DEF  = 64;
	localparam int DIGIT_STORE_DEF = 32;

	localparam logic [1:0] BASE_OCT = 2'd0;
	localparam logic [1:0] BASE_DEC = 2'd1;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_UPPER = 8'h41;
	localparam logic [7:0] ASCII_LOWER = 8'h61;
	localparam logic [7:0] ASCII_MINUS = 8'h2d;
	localparam logic [7:0] ASCII_SPACE = 8'h20;
	localparam logic [3:0] DIGIT_TEN   = 4'd10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_EXTRACT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic dabble;
		logic extract;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic in_decimal;
		logic dabble_done;
		logic extract_done;
		logic text_empty;
		logic emit_done;
	} sts_t;

	function automatic logic [7:0] digit_to_ascii(input logic [3:0] d, input logic upper);
		logic [7:0] c;
		if (d < DIGIT_TEN) begin
			c = ASCII_ZERO + {4'd0, d};
		end else begin
			c = (upper ? ASCII_UPPER : ASCII_LOWER) + {4'd0, d - DIGIT_TEN};
		end
		return c;
	endfunction

endpackage

// ===== rtl/i2a_fmt_ctl.sv =====
// Controller state machine of the integer to ASCII formatter.
// Depends on i2a_fmt_pkg; drives commands to and reads status from i2a_fmt_dp.
module i2a_fmt_ctl
	import i2a_fmt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.in_decimal ? ST_CONVERT : ST_EXTRACT;
				end
			end
			ST_CONVERT: begin
				cmd.dabble = 1'b1;
				if (sts.dabble_done) begin
					state_d = ST_EXTRACT;
				end
			end
			ST_EXTRACT: begin
				cmd.extract = 1'b1;
				if (sts.extract_done) begin
					state_d = sts.text_empty ? ST_IDLE : ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.emit_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// ===== rtl/i2a_fmt_dp.sv =====
// Datapath of the integer to ASCII formatter: magnitude, binary to BCD
// conversion, digit stack, padding and the output register.
// Depends on i2a_fmt_pkg; steered by i2a_fmt_ctl.
module i2a_fmt_dp
	import i2a_fmt_pkg::*;
#(
	parameter int VALUE_BITS  = VALUE_BITS_DEF,
	parameter int DIGIT_STORE = DIGIT_STORE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [63:0] value,
	input  logic [1:0]  base_select,
	input  logic        upper_case,
	input  logic        signed_mode,
	input  logic [5:0]  field_width,
	input  logic [5:0]  precision,
	input  logic        zero_pad,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  character,
	output logic [5:0]  char_index,
	output logic        last_char
);

	localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCD_BITS   = 4 * DEC_DIGITS;
	localparam int NDW        = $clog2(DIGIT_STORE + 1);
	localparam int CW         = $clog2(VALUE_BITS);
	localparam int LW         = 8;

	logic [VALUE_BITS-1:0] v_in;
	logic                  neg_in;
	logic [VALUE_BITS-1:0] mag_in;

	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_BITS-1:0]   work_q;
	logic [CW-1:0]         bitcnt_q;
	logic                  octal_q;
	logic                  upper_q;
	logic                  neg_q;
	logic [5:0]            width_q;
	logic                  has_prec_q;
	logic [4:0]            prec_q;
	logic                  zpad_q;
	logic [NDW-1:0]        nd_q;
	logic [3:0]            stack_q [DIGIT_STORE];
	logic [LW-1:0]         pos_q;
	logic                  out_valid_q;
	logic [7:0]            char_q;
	logic [5:0]            index_q;
	logic                  last_q;

	logic [BCD_BITS-1:0]   adj;
	logic [3:0]            new_digit;
	logic                  push;
	logic [LW-1:0]         len;
	logic [LW-1:0]         padn;
	logic [LW-1:0]         lead;
	logic [LW-1:0]         total;
	logic                  fire;
	logic                  in_digits;
	logic                  is_last;
	logic [7:0]            char_d;

	assign v_in   = value[VALUE_BITS-1:0];
	assign neg_in = signed_mode & v_in[VALUE_BITS-1];
	assign mag_in = neg_in ? VALUE_BITS'(~v_in + 1'b1) : v_in;

	always_comb begin
		for (int i = 0; i < DEC_DIGITS; i++) begin
			adj[4*i +: 4] = (work_q[4*i +: 4] >= 4'd5) ? work_q[4*i +: 4] + 4'd3
				: work_q[4*i +: 4];
		end
	end

	assign new_digit = octal_q ? {1'b0, work_q[2:0]} : work_q[3:0];
	assign push = (nd_q < NDW'(DIGIT_STORE)) &&
		((work_q != '0) || ((nd_q == '0) && !(has_prec_q && prec_q == '0)) ||
		 (has_prec_q && (LW'(prec_q) > LW'(nd_q))));

	assign len       = LW'(nd_q) + LW'(neg_q);
	assign padn      = (LW'(width_q) > len) ? LW'(width_q) - len : '0;
	assign lead      = padn + LW'(neg_q);
	assign total     = len + padn;
	assign in_digits = (pos_q >= lead);
	assign is_last   = (pos_q + 1'b1 == total);
	assign fire      = cmd.emit && (!out_valid_q || !out_stall);

	always_comb begin
		if (in_digits) begin
			char_d = digit_to_ascii(stack_q[0], upper_q);
		end else if (zpad_q) begin
			char_d = (neg_q && pos_q == '0) ? ASCII_MINUS : ASCII_ZERO;
		end else begin
			char_d = (pos_q < padn) ? ASCII_SPACE : ASCII_MINUS;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			octal_q    <= (base_select == BASE_OCT);
			upper_q    <= upper_case;
			neg_q      <= neg_in;
			width_q    <= field_width;
			has_prec_q <= !precision[5];
			prec_q     <= precision[4:0];
			zpad_q     <= zero_pad;
			mag_q      <= mag_in;
			work_q     <= (base_select == BASE_DEC) ? '0 : BCD_BITS'(mag_in);
			bitcnt_q   <= '0;
		end else if (cmd.dabble) begin
			work_q   <= {adj[BCD_BITS-2:0], mag_q[VALUE_BITS-1]};
			mag_q    <= {mag_q[VALUE_BITS-2:0], 1'b0};
			bitcnt_q <= bitcnt_q + 1'b1;
		end else if (cmd.extract && push) begin
			work_q <= octal_q ? (work_q >> 3) : (work_q >> 4);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.extract && push) begin
			stack_q[0] <= new_digit;
			for (int i = 1; i < DIGIT_STORE; i++) begin
				stack_q[i] <= stack_q[i-1];
			end
		end else if (fire && in_digits) begin
			for (int i = 0; i < DIGIT_STORE - 1; i++) begin
				stack_q[i] <= stack_q[i+1];
			end
			stack_q[DIGIT_STORE-1] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_q        <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				nd_q  <= '0;
				pos_q <= '0;
			end else if (cmd.extract && push) begin
				nd_q <= nd_q + 1'b1;
			end else if (fire) begin
				pos_q <= pos_q + 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			char_q  <= char_d;
			index_q <= pos_q[5:0];
			last_q  <= is_last;
		end
	end

	assign sts.in_decimal   = (base_select == BASE_DEC);
	assign sts.dabble_done  = (bitcnt_q == CW'(VALUE_BITS - 1));
	assign sts.extract_done = !push;
	assign sts.text_empty   = (total == '0);
	assign sts.emit_done    = fire && is_last;

	assign out_valid  = out_valid_q;
	assign character  = char_q;
	assign char_index = index_q;
	assign last_char  = last_q;

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter: controller plus datapath.
// Depends on i2a_fmt_pkg, i2a_fmt_ctl and i2a_fmt_dp.
//
// Takes one integer with its format choices and returns its printf-style text
// one character per transaction, most significant digit first, with the
// position and a last flag. One number is handled at a time. Decimal input
// first runs a binary to BCD conversion, one bit per cycle; all bases then
// push their digits onto the digit stack, and the text leaves at one
// character per cycle while the output side does not stall. The next number
// is taken once its last character has entered the output register.
module integer_to_ascii_formatter
	import i2a_fmt_pkg::*;
#(
	parameter int VALUE_BITS  = VALUE_BITS_DEF,
	parameter int DIGIT_STORE = DIGIT_STORE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] value,
	input  logic [1:0]  base_select,
	input  logic        upper_case,
	input  logic        signed_mode,
	input  logic [5:0]  field_width,
	input  logic [5:0]  precision,
	input  logic        zero_pad,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  character,
	output logic [5:0]  char_index,
	output logic        last_char
);

	cmd_t cmd;
	sts_t sts;

	i2a_fmt_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	i2a_fmt_dp #(
		.VALUE_BITS  (VALUE_BITS),
		.DIGIT_STORE (DIGIT_STORE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.value       (value),
		.base_select (base_select),
		.upper_case  (upper_case),
		.signed_mode (signed_mode),
		.field_width (field_width),
		.precision   (precision),
		.zero_pad    (zero_pad),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.character   (character),
		.char_index  (char_index),
		.last_char   (last_char)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a number was in progress");

	a_busy_mid_text: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_char) |-> in_stall)
		else $error("new number accepted before the text was complete");

	a_text_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (char_index == '0))
		else $error("text began at a non-zero position");

endmodule

// ===== sim/i2a_fmt_text_checker.sv =====
// Text checker for the integer to ASCII formatter: watches both channels,
// predicts the printf-style text of every accepted number and compares it.
// Depends on i2a_fmt_pkg for the character codes and the base codes.
module i2a_fmt_text_checker
	import i2a_fmt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [63:0] value,
	input  logic [1:0]  base_select,
	input  logic        upper_case,
	input  logic        signed_mode,
	input  logic [5:0]  field_width,
	input  logic [5:0]  precision,
	input  logic        zero_pad,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  character,
	input  logic [5:0]  char_index,
	input  logic        last_char,
	output int          mismatch_count,
	output int          chars_pending
);

	typedef struct packed {
		logic [7:0] code;
		logic [5:0] pos;
		logic       last;
	} text_char_t;

	text_char_t expected_chars[$];
	int fails = 0;
	int pending = 0;

	assign mismatch_count = fails;
	assign chars_pending  = pending;

	function automatic void predict_text(input logic [63:0] val, input logic [1:0] bsel,
		input logic upper, input logic sgn, input logic [5:0] width,
		input logic [5:0] prec_raw, input logic zpad);
		logic [7:0]  digit_chars[$];
		logic [7:0]  text[$];
		logic [63:0] mag;
		logic        neg;
		logic        has_prec;
		int unsigned radix;
		int unsigned digit;
		int unsigned prec;
		int unsigned len;
		int unsigned padn;
		int unsigned total;
		text_char_t  entry;

		neg = sgn && val[63];
		mag = neg ? (~val + 64'd1) : val;
		has_prec = !prec_raw[5];
		prec = has_prec ? prec_raw[4:0] : 0;
		radix = (bsel == BASE_OCT) ? 8 : (bsel == BASE_DEC) ? 10 : 16;

		if (mag == 64'd0 && !(has_prec && prec == 0))
			digit_chars.push_back(ASCII_ZERO);
		while (mag != 64'd0 && digit_chars.size() < DIGIT_STORE_DEF) begin
			digit = 32'(mag % 64'(radix));
			if (digit < 10)
				digit_chars.push_back(ASCII_ZERO + 8'(digit));
			else
				digit_chars.push_back((upper ? ASCII_UPPER : ASCII_LOWER) + 8'(digit - 10));
			mag = mag / 64'(radix);
		end
		while (has_prec && prec > digit_chars.size() && digit_chars.size() < DIGIT_STORE_DEF)
			digit_chars.push_back(ASCII_ZERO);

		len = digit_chars.size() + (neg ? 1 : 0);
		padn = (width > len) ? (width - len) : 0;
		total = len + padn;

		if (!zpad)
			repeat (padn) text.push_back(ASCII_SPACE);
		if (neg)
			text.push_back(ASCII_MINUS);
		if (zpad)
			repeat (padn) text.push_back(ASCII_ZERO);
		for (int i = digit_chars.size() - 1; i >= 0; i--)
			text.push_back(digit_chars[i]);

		for (int unsigned k = 0; k < total; k++) begin
			entry.code = text[k];
			entry.pos  = 6'(k);
			entry.last = (k + 1 == total);
			expected_chars.push_back(entry);
		end
	endfunction

	always @(posedge clk) begin : watch
		text_char_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_chars.size() == 0) begin
					fails++;
					$display("%0t: unexpected character: expected none, actual %h index %0d last %b",
						$time, character, char_index, last_char);
				end else begin
					want = expected_chars.pop_front();
					if (character !== want.code) begin
						fails++;
						$display("%0t: character mismatch: expected %h, actual %h",
							$time, want.code, character);
					end
					if (char_index !== want.pos) begin
						fails++;
						$display("%0t: char_index mismatch: expected %0d, actual %0d",
							$time, want.pos, char_index);
					end
					if (last_char !== want.last) begin
						fails++;
						$display("%0t: last_char mismatch: expected %b, actual %b",
							$time, want.last, last_char);
					end
				end
			end
			if (in_valid && !in_stall)
				predict_text(value, base_select, upper_case, signed_mode,
					field_width, precision, zero_pad);
			pending = expected_chars.size();
		end
	end

endmodule

// ===== sim/tb_integer_to_ascii_formatter.sv =====
// Testbench top for the integer to ASCII formatter: clock, reset, stimulus
// and verdict. Depends on i2a_fmt_pkg, the formatter RTL and i2a_fmt_text_checker.
module tb_integer_to_ascii_formatter
	import i2a_fmt_pkg::*;
();

	localparam logic [1:0] BASE_HEX     = 2'd2;
	localparam logic [1:0] BASE_HEX_ALT = 2'd3;
	localparam logic [5:0] PREC_NONE    = 6'h3f;
	localparam int         RANDOM_ITEMS = 146;
	localparam int         DRAIN_CYCLES = 200;
	localparam int         CYCLE_LIMIT  = 800000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] value = 64'd0;
	logic [1:0]  base_select = BASE_OCT;
	logic        upper_case = 1'b0;
	logic        signed_mode = 1'b0;
	logic [5:0]  field_width = 6'd0;
	logic [5:0]  precision = PREC_NONE;
	logic        zero_pad = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  character;
	logic [5:0]  char_index;
	logic        last_char;
	int          mismatch_count;
	int          chars_pending;
	logic        sender_quiet = 1'b0;

	integer_to_ascii_formatter DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.value(value), .base_select(base_select), .upper_case(upper_case),
		.signed_mode(signed_mode), .field_width(field_width),
		.precision(precision), .zero_pad(zero_pad),
		.out_valid(out_valid), .out_stall(out_stall),
		.character(character), .char_index(char_index), .last_char(last_char)
	);

	i2a_fmt_text_checker text_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.value(value), .base_select(base_select), .upper_case(upper_case),
		.signed_mode(signed_mode), .field_width(field_width),
		.precision(precision), .zero_pad(zero_pad),
		.out_valid(out_valid), .out_stall(out_stall),
		.character(character), .char_index(char_index), .last_char(last_char),
		.mismatch_count(mismatch_count), .chars_pending(chars_pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Stall the text side at random; hold off once for a long stretch.
	initial begin : text_side
		int unsigned taken;
		int unsigned hold;
		logic        quiet;
		taken = 0;
		quiet = 1'b0;
		forever begin
			if (taken % 32 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			hold = quiet ? 0 : $urandom_range(0, 9);
			if (taken == 600)
				hold = 500;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	task automatic send_number(input logic [63:0] v, input logic [1:0] b, input logic uc,
		input logic sm, input logic [5:0] w, input logic [5:0] p, input logic zp);
		int unsigned gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		value       <= v;
		base_select <= b;
		upper_case  <= uc;
		signed_mode <= sm;
		field_width <= w;
		precision   <= p;
		zero_pad    <= zp;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin : number_side
		logic [63:0] v;
		logic [5:0]  w;
		logic [5:0]  p;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_number(64'd0, BASE_DEC, 1'b0, 1'b0, 6'd0, PREC_NONE, 1'b0);
		send_number(64'd0, BASE_DEC, 1'b0, 1'b0, 6'd0, 6'd0, 1'b0);
		send_number(64'd0, BASE_HEX, 1'b0, 1'b1, 6'd5, 6'd0, 1'b0);
		send_number(64'd0, BASE_OCT, 1'b0, 1'b0, 6'd4, 6'd0, 1'b1);
		send_number('1, BASE_DEC, 1'b0, 1'b0, 6'd0, PREC_NONE, 1'b0);
		send_number('1, BASE_DEC, 1'b0, 1'b1, 6'd0, PREC_NONE, 1'b0);
		send_number(64'h8000_0000_0000_0000, BASE_DEC, 1'b0, 1'b1, 6'd25, PREC_NONE, 1'b1);
		send_number(64'h8000_0000_0000_0000, BASE_OCT, 1'b0, 1'b1, 6'd0, PREC_NONE, 1'b0);
		send_number('1, BASE_HEX, 1'b1, 1'b0, 6'd63, PREC_NONE, 1'b0);
		send_number('1, BASE_HEX, 1'b0, 1'b0, 6'd63, PREC_NONE, 1'b1);
		send_number(64'hdead_beef_cafe_f00d, BASE_HEX_ALT, 1'b1, 1'b0, 6'd0, PREC_NONE, 1'b0);
		send_number(-64'd42, BASE_DEC, 1'b0, 1'b1, 6'd10, PREC_NONE, 1'b1);
		send_number(-64'd42, BASE_DEC, 1'b0, 1'b1, 6'd10, PREC_NONE, 1'b0);
		send_number(64'd42, BASE_DEC, 1'b0, 1'b0, 6'd63, 6'd31, 1'b1);
		send_number(-64'd7, BASE_OCT, 1'b0, 1'b1, 6'd40, 6'd31, 1'b0);
		send_number(64'd12345, BASE_DEC, 1'b0, 1'b0, 6'd0, 6'h20, 1'b0);
		send_number(64'd12345, BASE_DEC, 1'b0, 1'b0, 6'd12, 6'h25, 1'b1);
		send_number(64'o1234567, BASE_OCT, 1'b0, 1'b0, 6'd3, 6'd10, 1'b0);
		send_number(64'd0, BASE_HEX, 1'b1, 1'b1, 6'd0, 6'd5, 1'b0);
		send_number(64'd0, BASE_DEC, 1'b0, 1'b0, 6'd63, PREC_NONE, 1'b1);
		send_number(64'd9, BASE_DEC, 1'b0, 1'b0, 6'd1, 6'd1, 1'b0);
		send_number(64'h7fff_ffff_ffff_ffff, BASE_DEC, 1'b0, 1'b1, 6'd0, PREC_NONE, 1'b0);
		send_number(64'h0123_4567_89ab_cdef, BASE_HEX, 1'b0, 1'b0, 6'd0, PREC_NONE, 1'b0);
		send_number(64'hfedc_ba98_7654_3210, BASE_HEX, 1'b1, 1'b1, 6'd20, 6'd18, 1'b1);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 16 == 0)
				sender_quiet = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 3))
				0: v = {$urandom, $urandom};
				1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
				2: v = -64'($urandom_range(0, 100000));
				default: v = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 3)) :
					{$urandom_range(0, 1) == 1, {63{$urandom_range(0, 1) == 1}}};
			endcase
			w = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) :
				6'($urandom_range(0, 16));
			case ($urandom_range(0, 3))
				0: p = PREC_NONE;
				1: p = 6'($urandom_range(0, 31));
				2: p = 6'($urandom_range(0, 63));
				default: p = 6'($urandom_range(0, 3));
			endcase
			send_number(v, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), w, p, 1'($urandom_range(0, 1)));
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (chars_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
